// File: sv/dclfb_pkg.sv
// Package for the dual-chip LCD frame store flush unit: sizes, codes and types.
`default_nettype none
package dclfb_pkg;

  localparam int unsigned COLUMNS_PER_CHIP = 64;
  localparam int unsigned PAGES            = 8;
  localparam int unsigned HALF_BYTES       = COLUMNS_PER_CHIP * PAGES;
  localparam int unsigned ALL_BYTES        = 2 * HALF_BYTES;
  localparam int unsigned STORE_DEPTH      = 1024;

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned COL_W   = $clog2(COLUMNS_PER_CHIP);
  localparam int unsigned PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] THRESH_RESET    = COUNT_W'(512);
  localparam logic [BYTE_W-1:0]  COL_OP_RESET    = BYTE_W'(64);
  localparam logic [BYTE_W-1:0]  PAGE_OP_RESET   = BYTE_W'(184);

  localparam logic [1:0] MASK_LEFT  = 2'b01;
  localparam logic [1:0] MASK_RIGHT = 2'b10;
  localparam logic [1:0] MASK_BOTH  = 2'b11;
  localparam logic [1:0] MASK_NONE  = 2'b00;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_START = 2'd2,
    MODE_STEP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH  = 2'd0,
    REG_COL_OP  = 2'd1,
    REG_PAGE_OP = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_PX_RD,
    ST_PX_WR,
    ST_DS_CMP,
    ST_DS_COL,
    ST_DS_PAGE,
    ST_DS_DATA,
    ST_WS_RDL,
    ST_WS_RDR,
    ST_WS_DAT1,
    ST_WS_DAT2
  } state_e;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [1:0]        mask;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } result_t;

endpackage
`default_nettype wire

// File: sv/dual_chip_lcd_framebuffer_flush_unit.sv
// Top level: frame store, sent store and flush sequencer for a two-chip LCD.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+------------------------
//  item    | mode_i pixel_x_i pixel_y_i pixel_on_i            | start_i && !busy_o
//  result  | write_kind_o chip_mask_o bus_byte_o last_o       | res_valid_o, one cycle
//          | flush_done_o                                     |
//  config  | cfg_index_i cfg_data_i                           | cfg_valid_i && cfg_ready_o
//
// Pixel write: read-modify-write of the frame memory (ST_PX_RD, then ST_PX_WR). Clear store:
// one frame word per cycle. Dirty step: bytes compared in turn, then column, page, data writes.
// Whole step: two reads on the single frame read port and up to four bus beats.
// After reset both memories are swept to zero with busy_o high.
// Results leave through an output register in the cycle after they are formed; no stall.
`default_nettype none
module dual_chip_lcd_framebuffer_flush_unit import dclfb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output      logic                  busy_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [7:0]            pixel_x_i,
  input  wire logic [6:0]            pixel_y_i,
  input  wire logic                  pixel_on_i,
  output      logic                  res_valid_o,
  output      logic [1:0]            write_kind_o,
  output      logic [1:0]            chip_mask_o,
  output      logic [7:0]            bus_byte_o,
  output      logic                  last_o,
  output      logic                  flush_done_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    sweep_q, sweep_d;
  logic [COUNT_W-1:0]   thresh_q;
  logic [BYTE_W-1:0]    col_op_q, page_op_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 active_q, active_d;
  logic                 whole_q, whole_d;
  logic [ADDR_W-1:0]    pos_addr_q, pos_addr_d;
  logic [COL_W-1:0]     pos_col_q, pos_col_d;
  logic [PAGE_W-1:0]    pos_page_q, pos_page_d;
  logic                 pos_half_q, pos_half_d;
  logic [ADDR_W-1:0]    pix_addr_q, pix_addr_d;
  logic [2:0]           pix_bit_q, pix_bit_d;
  logic                 pix_on_q, pix_on_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic [BYTE_W-1:0]    left_q, left_d;
  logic [BYTE_W-1:0]    right_q, right_d;
  result_t              res_q, res_d;

  logic [BYTE_W-1:0]    frame_mem [STORE_DEPTH];
  logic [BYTE_W-1:0]    sent_mem  [STORE_DEPTH];
  logic [BYTE_W-1:0]    frame_rd_q, sent_rd_q;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 fw_en, sw_en;
  logic [ADDR_W-1:0]    fw_addr, sw_addr;
  logic [BYTE_W-1:0]    fw_data, sw_data;

  // next scan position
  logic                 col_wrap, page_wrap, last_half, last_all;
  logic [COL_W-1:0]     nxt_col;
  logic [PAGE_W-1:0]    nxt_page;
  logic                 nxt_half;
  logic [ADDR_W-1:0]    nxt_addr;

  // pixel address decode
  logic                 on_panel, x_right;
  logic [7:0]           x_col;
  logic [COL_W-1:0]     in_col;
  logic [PAGE_W-1:0]    in_page;
  logic [ADDR_W-1:0]    in_addr;
  logic [BYTE_W-1:0]    pix_bit_mask;

  assign col_wrap  = (pos_col_q == COL_W'(COLUMNS_PER_CHIP - 1));
  assign page_wrap = (pos_page_q == PAGE_W'(PAGES - 1));
  assign last_half = col_wrap && page_wrap;
  assign last_all  = last_half && pos_half_q;
  assign nxt_col   = col_wrap ? '0 : pos_col_q + COL_W'(1);
  assign nxt_page  = !col_wrap ? pos_page_q : (page_wrap ? '0 : pos_page_q + PAGE_W'(1));
  assign nxt_half  = last_half ? !pos_half_q : pos_half_q;
  assign nxt_addr  = pos_addr_q + ADDR_W'(1);

  assign on_panel = ({1'b0, pixel_x_i} < 9'(2 * COLUMNS_PER_CHIP))
                 && ({1'b0, pixel_y_i} < 8'(8 * PAGES));
  assign x_right  = ({1'b0, pixel_x_i} >= 9'(COLUMNS_PER_CHIP));
  assign x_col    = x_right ? pixel_x_i - 8'(COLUMNS_PER_CHIP) : pixel_x_i;
  assign in_col   = COL_W'(x_col);
  assign in_page  = PAGE_W'(pixel_y_i[6:3]);
  assign in_addr  = (x_right ? ADDR_W'(HALF_BYTES) : ADDR_W'(0))
                  + ADDR_W'(in_page) * ADDR_W'(COLUMNS_PER_CHIP) + ADDR_W'(in_col);
  assign pix_bit_mask = BYTE_W'(1) << pix_bit_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    count_d    = count_q;
    active_d   = active_q;
    whole_d    = whole_q;
    pos_addr_d = pos_addr_q;
    pos_col_d  = pos_col_q;
    pos_page_d = pos_page_q;
    pos_half_d = pos_half_q;
    pix_addr_d = pix_addr_q;
    pix_bit_d  = pix_bit_q;
    pix_on_d   = pix_on_q;
    byte_d     = byte_q;
    left_d     = left_q;
    right_d    = right_q;
    rd_addr    = pos_addr_q;
    fw_en      = 1'b0;
    fw_addr    = sweep_q;
    fw_data    = '0;
    sw_en      = 1'b0;
    sw_addr    = sweep_q;
    sw_data    = '0;
    res_d.valid = 1'b0;
    res_d.kind  = KIND_NONE;
    res_d.mask  = MASK_NONE;
    res_d.data  = '0;
    res_d.last  = 1'b1;
    res_d.done  = 1'b0;

    case (state_q)
      ST_INIT: begin
        fw_en = 1'b1;
        sw_en = 1'b1;
        sweep_d = sweep_q + ADDR_W'(1);
        if (sweep_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          case (mode_e'(mode_i))
            MODE_PIXEL: begin
              pix_addr_d = in_addr;
              pix_bit_d  = pixel_y_i[2:0];
              pix_on_d   = pixel_on_i;
              if (on_panel) begin
                state_d = ST_PX_RD;
              end else begin
                res_d.valid = 1'b1;
              end
            end
            MODE_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLR;
            end
            MODE_START: begin
              active_d    = 1'b1;
              whole_d     = (count_q >= thresh_q);
              pos_addr_d  = '0;
              pos_col_d   = '0;
              pos_page_d  = '0;
              pos_half_d  = 1'b0;
              res_d.valid = 1'b1;
            end
            MODE_STEP: begin
              if (!active_q) begin
                res_d.valid = 1'b1;
              end else if (whole_q) begin
                state_d = ST_WS_RDL;
              end else begin
                // read of the current position goes out this cycle
                state_d = ST_DS_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        fw_en = 1'b1;
        sweep_d = sweep_q + ADDR_W'(1);
        if (sweep_q == ADDR_W'(STORE_DEPTH - 1)) begin
          res_d.valid = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_PX_RD: begin
        rd_addr = pix_addr_q;
        state_d = ST_PX_WR;
      end
      ST_PX_WR: begin
        fw_en   = 1'b1;
        fw_addr = pix_addr_q;
        fw_data = pix_on_q ? (frame_rd_q | pix_bit_mask) : (frame_rd_q & ~pix_bit_mask);
        if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
        end
        res_d.valid = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DS_CMP: begin
        // words at pos_addr_q are on the read ports
        if (frame_rd_q != sent_rd_q) begin
          byte_d  = frame_rd_q;
          state_d = ST_DS_COL;
        end else if (last_all) begin
          res_d.valid = 1'b1;
          res_d.done  = 1'b1;
          active_d    = 1'b0;
          count_d     = '0;
          pos_addr_d  = '0;
          pos_col_d   = '0;
          pos_page_d  = '0;
          pos_half_d  = 1'b0;
          state_d     = ST_IDLE;
        end else begin
          pos_addr_d = nxt_addr;
          pos_col_d  = nxt_col;
          pos_page_d = nxt_page;
          pos_half_d = nxt_half;
          rd_addr    = nxt_addr;
        end
      end
      ST_DS_COL: begin
        sw_en   = 1'b1;
        sw_addr = pos_addr_q;
        sw_data = byte_q;
        res_d.valid = 1'b1;
        res_d.kind  = KIND_CMD;
        res_d.mask  = pos_half_q ? MASK_RIGHT : MASK_LEFT;
        res_d.data  = col_op_q | BYTE_W'(pos_col_q);
        res_d.last  = 1'b0;
        state_d = ST_DS_PAGE;
      end
      ST_DS_PAGE: begin
        res_d.valid = 1'b1;
        res_d.kind  = KIND_CMD;
        res_d.mask  = pos_half_q ? MASK_RIGHT : MASK_LEFT;
        res_d.data  = page_op_q | BYTE_W'(pos_page_q);
        res_d.last  = 1'b0;
        state_d = ST_DS_DATA;
      end
      ST_DS_DATA: begin
        res_d.valid = 1'b1;
        res_d.kind  = KIND_DATA;
        res_d.mask  = pos_half_q ? MASK_RIGHT : MASK_LEFT;
        res_d.data  = byte_q;
        res_d.done  = last_all;
        if (last_all) begin
          active_d   = 1'b0;
          count_d    = '0;
          pos_addr_d = '0;
          pos_col_d  = '0;
          pos_page_d = '0;
          pos_half_d = 1'b0;
        end else begin
          pos_addr_d = nxt_addr;
          pos_col_d  = nxt_col;
          pos_page_d = nxt_page;
          pos_half_d = nxt_half;
        end
        state_d = ST_IDLE;
      end
      ST_WS_RDL: begin
        rd_addr = pos_addr_q;
        if (pos_col_q == '0) begin
          res_d.valid = 1'b1;
          res_d.kind  = KIND_CMD;
          res_d.mask  = MASK_BOTH;
          res_d.data  = col_op_q;
          res_d.last  = 1'b0;
        end
        state_d = ST_WS_RDR;
      end
      ST_WS_RDR: begin
        rd_addr = pos_addr_q + ADDR_W'(HALF_BYTES);
        left_d  = frame_rd_q;
        if (pos_col_q == '0) begin
          res_d.valid = 1'b1;
          res_d.kind  = KIND_CMD;
          res_d.mask  = MASK_BOTH;
          res_d.data  = page_op_q | BYTE_W'(pos_page_q);
          res_d.last  = 1'b0;
        end
        state_d = ST_WS_DAT1;
      end
      ST_WS_DAT1: begin
        right_d = frame_rd_q;
        sw_en   = 1'b1;
        sw_addr = pos_addr_q;
        sw_data = left_q;
        res_d.valid = 1'b1;
        res_d.kind  = KIND_DATA;
        res_d.data  = left_q;
        if (left_q == frame_rd_q) begin
          res_d.mask = MASK_BOTH;
          res_d.done = last_half;
        end else begin
          res_d.mask = MASK_LEFT;
          res_d.last = 1'b0;
        end
        state_d = ST_WS_DAT2;
      end
      ST_WS_DAT2: begin
        // right half write-back; second data beat only when the halves differ
        sw_en   = 1'b1;
        sw_addr = pos_addr_q + ADDR_W'(HALF_BYTES);
        sw_data = right_q;
        if (left_q != right_q) begin
          res_d.valid = 1'b1;
          res_d.kind  = KIND_DATA;
          res_d.mask  = MASK_RIGHT;
          res_d.data  = right_q;
          res_d.done  = last_half;
        end
        if (last_half) begin
          active_d   = 1'b0;
          count_d    = '0;
          pos_addr_d = '0;
          pos_col_d  = '0;
          pos_page_d = '0;
        end else begin
          pos_addr_d = nxt_addr;
          pos_col_d  = nxt_col;
          pos_page_d = nxt_page;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      sweep_q    <= '0;
      count_q    <= '0;
      active_q   <= 1'b0;
      whole_q    <= 1'b0;
      pos_addr_q <= '0;
      pos_col_q  <= '0;
      pos_page_q <= '0;
      pos_half_q <= 1'b0;
      res_q      <= '0;
      thresh_q   <= THRESH_RESET;
      col_op_q   <= COL_OP_RESET;
      page_op_q  <= PAGE_OP_RESET;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      count_q    <= count_d;
      active_q   <= active_d;
      whole_q    <= whole_d;
      pos_addr_q <= pos_addr_d;
      pos_col_q  <= pos_col_d;
      pos_page_q <= pos_page_d;
      pos_half_q <= pos_half_d;
      res_q      <= res_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_THRESH:  thresh_q  <= cfg_data_i;
          REG_COL_OP:  col_op_q  <= cfg_data_i[BYTE_W-1:0];
          REG_PAGE_OP: page_op_q <= cfg_data_i[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_addr_q <= pix_addr_d;
    pix_bit_q  <= pix_bit_d;
    pix_on_q   <= pix_on_d;
    byte_q     <= byte_d;
    left_q     <= left_d;
    right_q    <= right_d;
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) begin
      frame_mem[fw_addr] <= fw_data;
    end
    frame_rd_q <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      sent_mem[sw_addr] <= sw_data;
    end
    sent_rd_q <= sent_mem[rd_addr];
  end

  assign res_valid_o  = res_q.valid;
  assign write_kind_o = res_q.kind;
  assign chip_mask_o  = res_q.mask;
  assign bus_byte_o   = res_q.data;
  assign last_o       = res_q.last;
  assign flush_done_o = res_q.done;

endmodule
`default_nettype wire

// File: verif/dual_chip_lcd_framebuffer_flush_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-chip LCD flush unit: directed table, then random traffic.
module dual_chip_lcd_framebuffer_flush_unit_test import dclfb_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // past the last register, must be ignored
  localparam int unsigned PANEL_W   = 2 * COLUMNS_PER_CHIP;
  localparam int unsigned PANEL_H   = 8 * PAGES;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        mask;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } bus_write_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] x;
    logic [6:0] y;
    logic       on_bit;
    logic       typed;
    logic       done;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            mode_i;
  logic [7:0]            pixel_x_i;
  logic [6:0]            pixel_y_i;
  logic                  pixel_on_i;
  logic                  res_valid_o;
  logic [1:0]            write_kind_o;
  logic [1:0]            chip_mask_o;
  logic [7:0]            bus_byte_o;
  logic                  last_o;
  logic                  flush_done_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dual_chip_lcd_framebuffer_flush_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_on_i   (pixel_on_i),
    .res_valid_o  (res_valid_o),
    .write_kind_o (write_kind_o),
    .chip_mask_o  (chip_mask_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o),
    .flush_done_o (flush_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Mirror of the block: wanted image, panel image, counters and registers
  logic [BYTE_W-1:0]  frame_img [ALL_BYTES];
  logic [BYTE_W-1:0]  panel_img [ALL_BYTES];
  logic [COUNT_W-1:0] change_cnt;
  logic               flushing;
  logic               whole_mode;
  int unsigned        scan_pos;
  logic [COUNT_W-1:0] thresh_r;
  logic [BYTE_W-1:0]  col_op_r;
  logic [BYTE_W-1:0]  page_op_r;

  bus_write_t  item_writes[$];
  bus_write_t  expected_writes[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned idle_pct;

  plan_row_t directed_rows [23] = '{
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b1, 1'b0},  // no flush running
    '{MODE_START, 8'd0,   7'd0,   1'b0, 1'b1, 1'b0},
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b1, 1'b1},  // nothing dirty: ends at once
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd0,   7'd0,   1'b1, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd127, 7'd63,  1'b1, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd128, 7'd0,   1'b1, 1'b1, 1'b0},  // off panel
    '{MODE_PIXEL, 8'd255, 7'd127, 1'b1, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd0,   7'd64,  1'b1, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd64,  7'd7,   1'b1, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd63,  7'd8,   1'b1, 1'b1, 1'b0},
    '{MODE_PIXEL, 8'd0,   7'd0,   1'b0, 1'b1, 1'b0},  // back to what the panel holds
    '{MODE_START, 8'd255, 7'd127, 1'b1, 1'b1, 1'b0},
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{MODE_START, 8'd0,   7'd0,   1'b0, 1'b1, 1'b0},  // restart mid-scan
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b0, 1'b0},  // final byte ends the scan
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b1, 1'b0},
    '{MODE_CLEAR, 8'd0,   7'd0,   1'b0, 1'b1, 1'b0},
    '{MODE_START, 8'd0,   7'd0,   1'b0, 1'b1, 1'b0},
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{MODE_STEP,  8'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{MODE_PIXEL, 8'd5,   7'd20,  1'b1, 1'b1, 1'b0}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic flag_error(string what);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void emit(kind_e kind, logic [1:0] mask, logic [BYTE_W-1:0] data);
    item_writes.push_back('{kind, mask, data, 1'b0, 1'b0});
  endfunction

  function automatic void close_item(logic done);
    if (item_writes.size() == 0) emit(KIND_NONE, MASK_NONE, '0);
    item_writes[item_writes.size()-1].last = 1'b1;
    item_writes[item_writes.size()-1].done = done;
    if (done) begin
      flushing   = 1'b0;
      change_cnt = '0;
    end
  endfunction

  function automatic void dirty_step();
    int          hit;
    int unsigned offs;
    logic [1:0]  mask;
    hit = -1;
    for (int i = scan_pos; i < ALL_BYTES; i++) begin
      if (hit < 0 && frame_img[i] != panel_img[i]) hit = i;
    end
    if (hit < 0) begin
      scan_pos = 0;
      close_item(1'b1);
    end else begin
      offs = hit % HALF_BYTES;
      mask = (hit >= HALF_BYTES) ? MASK_RIGHT : MASK_LEFT;
      emit(KIND_CMD, mask, col_op_r | BYTE_W'(offs % COLUMNS_PER_CHIP));
      emit(KIND_CMD, mask, page_op_r | BYTE_W'(offs / COLUMNS_PER_CHIP));
      emit(KIND_DATA, mask, frame_img[hit]);
      panel_img[hit] = frame_img[hit];
      scan_pos = hit + 1;
      close_item(scan_pos >= ALL_BYTES);
    end
  endfunction

  function automatic void whole_step();
    int unsigned       pos;
    logic [BYTE_W-1:0] lbyte;
    logic [BYTE_W-1:0] rbyte;
    pos = scan_pos;
    if (pos >= HALF_BYTES) begin
      scan_pos = 0;
      close_item(1'b1);
    end else begin
      // page header goes to both chips at the start of each page
      if (pos % COLUMNS_PER_CHIP == 0) begin
        emit(KIND_CMD, MASK_BOTH, col_op_r);
        emit(KIND_CMD, MASK_BOTH, page_op_r | BYTE_W'(pos / COLUMNS_PER_CHIP));
      end
      lbyte = frame_img[pos];
      rbyte = frame_img[pos + HALF_BYTES];
      if (lbyte == rbyte) begin
        emit(KIND_DATA, MASK_BOTH, lbyte);
      end else begin
        emit(KIND_DATA, MASK_LEFT, lbyte);
        emit(KIND_DATA, MASK_RIGHT, rbyte);
      end
      panel_img[pos]              = lbyte;
      panel_img[pos + HALF_BYTES] = rbyte;
      scan_pos = pos + 1;
      close_item(scan_pos >= HALF_BYTES);
    end
  endfunction

  function automatic void compute_bus_writes(mode_e mode, logic [7:0] x, logic [6:0] y,
                                             logic on_bit);
    int unsigned addr;
    item_writes.delete();
    case (mode)
      MODE_PIXEL: begin
        if (x < PANEL_W && y < PANEL_H) begin
          addr = (x / COLUMNS_PER_CHIP) * HALF_BYTES + (y / 8) * COLUMNS_PER_CHIP
               + x % COLUMNS_PER_CHIP;
          frame_img[addr][y % 8] = on_bit;
          if (change_cnt != COUNT_MAX) change_cnt = change_cnt + 1'b1;
        end
        close_item(1'b0);
      end
      MODE_CLEAR: begin
        for (int i = 0; i < ALL_BYTES; i++) frame_img[i] = '0;
        close_item(1'b0);
      end
      MODE_START: begin
        flushing   = 1'b1;
        whole_mode = (change_cnt >= thresh_r);
        scan_pos   = 0;
        close_item(1'b0);
      end
      default: begin
        if (!flushing) close_item(1'b0);
        else if (whole_mode) whole_step();
        else dirty_step();
      end
    endcase
  endfunction

  // start_i is left high after a beat; the next call lowers it only for a gap
  task automatic send_item(mode_e mode, logic [7:0] x, logic [6:0] y, logic on_bit,
                           logic typed = 1'b0, logic typed_done = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    mode_i     <= mode;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    pixel_on_i <= on_bit;
    do @(posedge clk_i); while (busy_o);
    compute_bus_writes(mode, x, y, on_bit);
    if (typed) expected_writes.push_back('{KIND_NONE, MASK_NONE, 8'h00, 1'b1, typed_done});
    else foreach (item_writes[i]) expected_writes.push_back(item_writes[i]);
    if (!(mode == MODE_PIXEL && (x >= PANEL_W || y >= PANEL_H))) items_sent++;
  endtask

  task automatic send_pixel(logic on_panel);
    logic [7:0] x;
    logic [6:0] y;
    if (on_panel) begin
      x = 8'($urandom_range(PANEL_W - 1));
      y = 7'($urandom_range(PANEL_H - 1));
    end else if ($urandom_range(1)) begin
      x = 8'($urandom_range(255, PANEL_W));
      y = 7'($urandom);
    end else begin
      x = 8'($urandom);
      y = 7'($urandom_range(127, PANEL_H));
    end
    send_item(MODE_PIXEL, x, y, 1'($urandom));
  endtask

  task automatic send_step();
    send_item(MODE_STEP, 8'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic flush_some(int unsigned max_steps);
    int unsigned n;
    send_item(MODE_START, 8'($urandom), 7'($urandom), 1'($urandom));
    n = 0;
    while (flushing && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_THRESH:  thresh_r  = data;
      REG_COL_OP:  col_op_r  = data[BYTE_W-1:0];
      REG_PAGE_OP: page_op_r = data[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // opcode writes carry junk in the unused top bits
  task automatic set_regs(logic [COUNT_W-1:0] thresh, logic [BYTE_W-1:0] col_op,
                          logic [BYTE_W-1:0] page_op);
    cfg_write(REG_THRESH, thresh);
    cfg_write(REG_COL_OP, {3'($urandom), col_op});
    cfg_write(REG_PAGE_OP, {3'($urandom), page_op});
    cfg_write(REG_NONE, 11'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        repeat ($urandom_range(10, 1)) send_pixel($urandom_range(7) != 0);
        flush_some(($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(60, 2));
      end else if (pick < 65) begin
        repeat ($urandom_range(20, 1)) send_pixel($urandom_range(7) != 0);
      end else if (pick < 75) begin
        send_item(mode_e'($urandom_range(3)), 8'($urandom), 7'($urandom), 1'($urandom));
      end else if (pick < 85) begin
        send_step();
      end else if (pick < 92) begin
        send_item(MODE_START, 8'($urandom), 7'($urandom), 1'($urandom));
        repeat ($urandom_range(4, 1)) send_step();
      end else if (pick < 97) begin
        send_item(MODE_CLEAR, 8'($urandom), 7'($urandom), 1'($urandom));
        flush_some($urandom_range(60, 2));
      end else begin
        drain_results();
      end
    end
  endtask

  always @(posedge clk_i) begin
    bus_write_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_writes.size() == 0) begin
        flag_error("bus write with nothing expected");
      end else begin
        want = expected_writes.pop_front();
        if (write_kind_o !== want.kind)
          flag_error($sformatf("write_kind got %0d want %0d", write_kind_o, want.kind));
        if (chip_mask_o !== want.mask)
          flag_error($sformatf("chip_mask got %0d want %0d", chip_mask_o, want.mask));
        if (bus_byte_o !== want.data)
          flag_error($sformatf("bus_byte got %02h want %02h", bus_byte_o, want.data));
        if (last_o !== want.last)
          flag_error($sformatf("last got %0b want %0b", last_o, want.last));
        if (flush_done_o !== want.done)
          flag_error($sformatf("flush_done got %0b want %0b", flush_done_o, want.done));
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    mode_i      <= MODE_PIXEL;
    pixel_x_i   <= '0;
    pixel_y_i   <= '0;
    pixel_on_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_THRESH;
    cfg_data_i  <= '0;
    for (int i = 0; i < ALL_BYTES; i++) begin
      frame_img[i] = '0;
      panel_img[i] = '0;
    end
    change_cnt = '0;
    flushing   = 1'b0;
    whole_mode = 1'b0;
    scan_pos   = 0;
    thresh_r   = THRESH_RESET;
    col_op_r   = COL_OP_RESET;
    page_op_r  = PAGE_OP_RESET;
    mismatches = 0;
    items_sent = 0;
    idle_pct   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].on_bit, directed_rows[i].typed, directed_rows[i].done);
    drain_results();

    // zero threshold: every flush is whole-frame, one run to the very end
    set_regs('0, 8'h00, 8'h00);
    random_traffic(10);
    flush_some(ALL_BYTES + 1);
    drain_results();

    set_regs(COUNT_W'(1024), 8'hFF, 8'hFF);
    idle_pct = 73;
    random_traffic(30);
    drain_results();

    set_regs(COUNT_W'($urandom_range(40, 1)), 8'($urandom), 8'($urandom));
    idle_pct = 10;
    random_traffic(30);
    drain_results();

    set_regs(COUNT_W'($urandom_range(1024)), 8'($urandom), 8'($urandom));
    idle_pct = 73;
    random_traffic(15);
    idle_pct = 0;
    random_traffic(15);
    drain_results();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
